[sv/htc_pkg.sv]
package htc_pkg;

   localparam int MAX_SYMBOLS = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
   localparam int IDX_BITS    = $clog2(NODE_COUNT);
   localparam int SYM_BITS    = 5;
   localparam int CNT_BITS    = 6;
   localparam int SUM_BITS    = WEIGHT_BITS + $clog2(MAX_SYMBOLS) + 1;
   localparam int LINK_BITS   = 7;
   localparam int CODE_BITS   = 31;
   localparam int LEN_BITS    = 5;
   localparam int IN_W_BITS   = 16;
   localparam logic [LINK_BITS-1:0] NO_NODE = '1;
   localparam logic [LEN_BITS-1:0]  MAX_LEN = LEN_BITS'(CODE_BITS);
   localparam logic [CNT_BITS-1:0]  COUNT_RESET = CNT_BITS'(27);
   localparam logic                 REG_SYMBOL_COUNT = 1'b0;

   typedef enum logic [1:0] {
      OP_LOAD, OP_BUILD, OP_ENCODE, OP_DECODE
   } op_type;

   typedef enum logic [1:0] {
      ST_OK, ST_NOT_BUILT, ST_BAD_INDEX
   } status_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_ACCEPT, ACT_CLEAR, ACT_SCAN, ACT_MERGE_NEW, ACT_MERGE_A,
      ACT_MERGE_B, ACT_ENC_PAR, ACT_ENC_LEFT, ACT_DEC_STEP, ACT_EMIT
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_SCAN, S_DRAIN, S_MERGE_NEW, S_MERGE_A, S_MERGE_B,
      S_ENC_PAR, S_ENC_LEFT, S_DEC_STEP, S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      action_type action;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   tree_ready;
      logic   index_bad;
      logic   clear_last;
      logic   scan_last;
      logic   merge_last;
      logic   enc_done;
      logic   out_free;
   } stat_type;

   function automatic logic [CNT_BITS-1:0] active_count(input logic [CNT_BITS-1:0] c);
      logic [CNT_BITS-1:0] r;
      r = c;
      if (c < CNT_BITS'(2)) r = CNT_BITS'(2);
      if (c > CNT_BITS'(MAX_SYMBOLS)) r = CNT_BITS'(MAX_SYMBOLS);
      return r;
   endfunction

endpackage

[sv/huffman_tree_codec.sv]
// Huffman tree codec: load weight, build tree, encode symbol, decode one bit.
// Load and not-built or bad-index items go from accept straight to the result stage.
// Decode: one node-store read. Encode: a parent walk, reading parent then left child per code bit.
// Build: clear n parent links, then per merge scan the i nodes so far, drain, write node and parents.
// One item at a time; synchronous active-high reset clears control, count to 27, no tree.
module huffman_tree_codec
   import htc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // op
   input  logic [23:0] req_tdata,   // symbol_index, weight, bit_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status, symbol_valid
   output logic [47:0] rsp_tdata,   // symbol, code_bits, code_length
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_pready = 1'b1;

   htc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .stat(stat), .cmd(cmd)
   );

   htc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata)
   );

endmodule

[sv/htc_ctrl.sv]
module htc_ctrl
   import htc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.action = ACT_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.action = ACT_ACCEPT;
               unique case (stat.op)
                  OP_LOAD:   state_in = S_FINISH;
                  OP_BUILD:  state_in = S_CLEAR;
                  OP_ENCODE: state_in = (!stat.tree_ready || stat.index_bad) ? S_FINISH
                                                                             : S_ENC_PAR;
                  OP_DECODE: state_in = stat.tree_ready ? S_DEC_STEP : S_FINISH;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.action = ACT_CLEAR;
            if (stat.clear_last) state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.action = ACT_SCAN;
            if (stat.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN:     state_in = S_MERGE_NEW;
         S_MERGE_NEW: begin
            cmd.action = ACT_MERGE_NEW;
            state_in   = S_MERGE_A;
         end
         S_MERGE_A: begin
            cmd.action = ACT_MERGE_A;
            state_in   = S_MERGE_B;
         end
         S_MERGE_B: begin
            cmd.action = ACT_MERGE_B;
            state_in   = stat.merge_last ? S_FINISH : S_SCAN;
         end
         S_ENC_PAR: begin
            if (stat.enc_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.action = ACT_ENC_PAR;
               state_in   = S_ENC_LEFT;
            end
         end
         S_ENC_LEFT: begin
            cmd.action = ACT_ENC_LEFT;
            state_in   = S_ENC_PAR;
         end
         S_DEC_STEP: begin
            cmd.action = ACT_DEC_STEP;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.action = ACT_EMIT;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[sv/htc_datapath.sv]
module htc_datapath
   import htc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_tuser,
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata
);

   // node store
   logic [SUM_BITS-1:0]  weight_ff [NODE_COUNT];
   logic [LINK_BITS-1:0] parent_ff [NODE_COUNT];
   logic [IDX_BITS-1:0]  left_ff   [NODE_COUNT];
   logic [IDX_BITS-1:0]  right_ff  [NODE_COUNT];

   logic [SUM_BITS-1:0]  w_rd_ff;
   logic [LINK_BITS-1:0] p_rd_ff;
   logic [IDX_BITS-1:0]  l_rd_ff, r_rd_ff;

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 ready_ff, ready_in;
   logic [IDX_BITS-1:0]  pos_ff, pos_in;
   logic [IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]  node_ff, node_in;
   logic [IDX_BITS-1:0]  jd_ff, jd_in;
   logic                 pend_ff, pend_in;
   logic [IDX_BITS-1:0]  b1_ff, b1_in, b2_ff, b2_in;
   logic [SUM_BITS-1:0]  w1_ff, w1_in, w2_ff, w2_in;
   logic                 f1_ff, f1_in, f2_ff, f2_in;
   logic [IDX_BITS-1:0]  cur_ff, cur_in, nxt_ff, nxt_in;
   logic                 bit_ff, bit_in;
   status_type           status_ff, status_in;
   logic                 sval_ff, sval_in;
   logic [SYM_BITS-1:0]  sym_ff, sym_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 ovalid_ff, ovalid_in;
   logic [2:0]           ouser_ff, ouser_in;
   logic [47:0]          odata_ff, odata_in;

   logic [IDX_BITS-1:0]  rd_addr;
   logic                 w_we, p_we, lr_we;
   logic [IDX_BITS-1:0]  w_addr, p_addr;
   logic [SUM_BITS-1:0]  w_data;
   logic [LINK_BITS-1:0] p_data;

   logic [CNT_BITS-1:0]  n, root;
   logic [SYM_BITS-1:0]  req_idx;
   logic [IN_W_BITS-1:0] req_w;
   logic                 cfg_wr, idx_bad, elig;
   logic [IDX_BITS-1:0]  pos_rd, dec_nxt;
   op_type               req_op;

   assign req_op  = op_type'(req_tuser);
   assign req_idx = req_tdata[4:0];
   assign req_w   = req_tdata[20:5];
   assign n       = active_count(count_ff);
   assign root    = CNT_BITS'({n, 1'b0} - 7'd2);
   assign idx_bad = {1'b0, req_idx} >= n;
   assign pos_rd  = (pos_ff > root) ? root : pos_ff;
   assign dec_nxt = bit_ff ? r_rd_ff : l_rd_ff;
   assign elig    = (p_rd_ff == NO_NODE);
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_SYMBOL_COUNT);

   assign csr_prdata = (csr_paddr[2] == REG_SYMBOL_COUNT) ? {26'd0, count_ff} : 32'd0;

   assign stat.op         = req_op;
   assign stat.tree_ready = ready_ff;
   assign stat.index_bad  = idx_bad;
   assign stat.clear_last = (cnt_ff == n - 6'd1);
   assign stat.scan_last  = (cnt_ff == node_ff - 6'd1);
   assign stat.merge_last = (node_ff == root);
   assign stat.enc_done   = (p_rd_ff == NO_NODE) || (len_ff == MAX_LEN);
   assign stat.out_free   = !ovalid_ff || rsp_tready;

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tdata  = odata_ff;

   always_comb begin
      unique case (cmd.action)
         ACT_ACCEPT:   rd_addr = (req_op == OP_DECODE) ? pos_rd : {1'b0, req_idx};
         ACT_SCAN:     rd_addr = cnt_ff;
         ACT_ENC_PAR:  rd_addr = p_rd_ff[IDX_BITS-1:0];
         ACT_ENC_LEFT: rd_addr = nxt_ff;
         default:      rd_addr = '0;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      ready_in  = ready_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      node_in   = node_ff;
      jd_in     = cnt_ff;
      pend_in   = (cmd.action == ACT_SCAN);
      b1_in = b1_ff; b2_in = b2_ff; w1_in = w1_ff; w2_in = w2_ff;
      f1_in = f1_ff; f2_in = f2_ff;
      cur_in    = cur_ff;
      nxt_in    = nxt_ff;
      bit_in    = bit_ff;
      status_in = status_ff;
      sval_in   = sval_ff;
      sym_in    = sym_ff;
      code_in   = code_ff;
      len_in    = len_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      ouser_in  = ouser_ff;
      odata_in  = odata_ff;
      w_we = 1'b0; p_we = 1'b0; lr_we = 1'b0;
      w_addr = {1'b0, req_idx};
      w_data = SUM_BITS'(req_w);
      p_addr = cnt_ff;
      p_data = NO_NODE;

      if (cfg_wr) begin
         count_in = csr_pwdata[CNT_BITS-1:0];
         ready_in = 1'b0;
         pos_in   = '0;
      end

      // running two-smallest over parentless nodes; strict compare keeps lowest index
      if (pend_ff) begin
         if (elig) begin
            if (!f1_ff || w_rd_ff < w1_ff) begin
               b2_in = b1_ff; w2_in = w1_ff; f2_in = f1_ff;
               b1_in = jd_ff; w1_in = w_rd_ff; f1_in = 1'b1;
            end else if (!f2_ff || w_rd_ff < w2_ff) begin
               b2_in = jd_ff; w2_in = w_rd_ff; f2_in = 1'b1;
            end
         end
      end else if (cmd.action == ACT_SCAN && cnt_ff == '0) begin
         f1_in = 1'b0;
         f2_in = 1'b0;
      end

      unique case (cmd.action)
         ACT_ACCEPT: begin
            status_in = ST_OK;
            sval_in   = 1'b0;
            sym_in    = '0;
            code_in   = '0;
            len_in    = '0;
            cur_in    = {1'b0, req_idx};
            bit_in    = req_tdata[21];
            cnt_in    = '0;
            unique case (req_op)
               OP_LOAD: begin
                  if (idx_bad) status_in = ST_BAD_INDEX;
                  else w_we = 1'b1;
               end
               OP_BUILD: ;
               OP_ENCODE: begin
                  if (!ready_ff) status_in = ST_NOT_BUILT;
                  else if (idx_bad) status_in = ST_BAD_INDEX;
               end
               OP_DECODE: if (!ready_ff) status_in = ST_NOT_BUILT;
               default: ;
            endcase
         end
         ACT_CLEAR: begin
            p_we = 1'b1;
            if (stat.clear_last) begin
               cnt_in  = '0;
               node_in = n;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ACT_SCAN: cnt_in = cnt_ff + 6'd1;
         ACT_MERGE_NEW: begin
            w_we   = 1'b1;
            w_addr = node_ff;
            w_data = w1_ff + w2_ff;
            lr_we  = 1'b1;
            p_we   = 1'b1;
            p_addr = node_ff;
         end
         ACT_MERGE_A: begin
            p_we   = 1'b1;
            p_addr = b1_ff;
            p_data = {1'b0, node_ff};
         end
         ACT_MERGE_B: begin
            p_we   = 1'b1;
            p_addr = b2_ff;
            p_data = {1'b0, node_ff};
            cnt_in = '0;
            if (stat.merge_last) begin
               ready_in = 1'b1;
               pos_in   = root;
            end else begin
               node_in = node_ff + 6'd1;
            end
         end
         ACT_ENC_PAR: nxt_in = p_rd_ff[IDX_BITS-1:0];
         ACT_ENC_LEFT: begin
            if (l_rd_ff != cur_ff) code_in[len_ff] = 1'b1;
            len_in = len_ff + 5'd1;
            cur_in = nxt_ff;
         end
         ACT_DEC_STEP: begin
            if (dec_nxt > root) begin
               pos_in = root;
            end else if (dec_nxt < n) begin
               sval_in = 1'b1;
               sym_in  = dec_nxt[SYM_BITS-1:0];
               pos_in  = root;
            end else begin
               pos_in = dec_nxt;
            end
         end
         ACT_EMIT: begin
            ovalid_in = 1'b1;
            ouser_in  = {sval_ff, status_ff};
            odata_in  = {7'd0, len_ff, code_ff, sym_ff};
         end
         ACT_NONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) weight_ff[w_addr] <= w_data;
      if (p_we) parent_ff[p_addr] <= p_data;
      if (lr_we) begin
         left_ff[node_ff]  <= b1_ff;
         right_ff[node_ff] <= b2_ff;
      end
      w_rd_ff <= weight_ff[rd_addr];
      p_rd_ff <= parent_ff[rd_addr];
      l_rd_ff <= left_ff[rd_addr];
      r_rd_ff <= right_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_RESET;
         ready_ff  <= 1'b0;
         pos_ff    <= '0;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ready_ff  <= ready_in;
         pos_ff    <= pos_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; node_ff <= node_in; jd_ff <= jd_in;
      b1_ff <= b1_in; b2_ff <= b2_in; w1_ff <= w1_in; w2_ff <= w2_in;
      f1_ff <= f1_in; f2_ff <= f2_in;
      cur_ff <= cur_in; nxt_ff <= nxt_in; bit_ff <= bit_in;
      status_ff <= status_in; sval_ff <= sval_in; sym_ff <= sym_in;
      code_ff <= code_in; len_ff <= len_in;
      ouser_ff <= ouser_in; odata_ff <= odata_in;
   end

   a_merge_two: assert property (@(posedge clock) disable iff (reset)
      cmd.action == ACT_MERGE_NEW |-> f1_ff && f2_ff && b1_ff != b2_ff)
      else $error("merge without two distinct nodes");

   a_merge_range: assert property (@(posedge clock) disable iff (reset)
      cmd.action == ACT_MERGE_NEW |-> node_ff <= root && node_ff >= n)
      else $error("merge node out of range");

   a_leaf_parent: assert property (@(posedge clock) disable iff (reset)
      cmd.action == ACT_ENC_PAR && len_ff == '0 |-> p_rd_ff != NO_NODE)
      else $error("leaf without parent");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.action == ACT_EMIT |-> !ovalid_ff || rsp_tready)
      else $error("result overwritten");

endmodule

[tb/sv/huffman_tree_codec_tb.sv]
module huffman_tree_codec_tb;
   import htc_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // op
   logic [23:0] req_tdata;    // symbol_index[4:0], weight[20:5], bit_value[21]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;    // status[1:0], symbol_valid[2]
   logic [47:0] rsp_tdata;    // symbol[4:0], code_bits[35:5], code_length[40:36]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   huffman_tree_codec dut (.*);

   typedef struct {
      status_type      st;
      logic            sym_valid;
      logic [4:0]      sym;
      logic [30:0]     code;
      logic [4:0]      len;
   } answer_type;

   typedef struct {
      op_type      op;
      logic [4:0]  idx;
      logic [15:0] wt;
      logic        bv;
      bit          typed;
      status_type  st;
   } row_type;

   // codec model state
   logic [5:0]           cnt_reg;
   longint unsigned      wgt[NODE_COUNT];
   logic [LINK_BITS-1:0] par[NODE_COUNT];
   logic [LINK_BITS-1:0] lft[NODE_COUNT];
   logic [LINK_BITS-1:0] rgt[NODE_COUNT];
   int unsigned          dec_pos;
   bit                   built;

   answer_type pending_answers[$];
   int      errors;
   bit      calm;
   int      stall_cnt;

   function automatic int unsigned live_count();
      int unsigned c;
      c = cnt_reg;
      if (c < 2) c = 2;
      if (c > MAX_SYMBOLS) c = MAX_SYMBOLS;
      return c;
   endfunction

   function automatic int unsigned lowest_free(int unsigned lim, int unsigned skip,
                                               output bit found);
      int unsigned best;
      longint unsigned bw;
      best = 0;
      bw = 0;
      found = 0;
      for (int unsigned j = 0; j < lim; j++) begin
         if (j == skip || par[j] != NO_NODE) continue;
         if (!found || wgt[j] < bw) begin
            found = 1;
            best = j;
            bw = wgt[j];
         end
      end
      return best;
   endfunction

   function automatic void grow_tree(int unsigned n);
      int unsigned a, b;
      bit f1, f2;
      for (int unsigned i = 0; i < n; i++) begin
         par[i] = NO_NODE;
         lft[i] = NO_NODE;
         rgt[i] = NO_NODE;
      end
      for (int unsigned i = n; i < 2 * n - 1; i++) begin
         a = lowest_free(i, NO_NODE, f1);
         b = lowest_free(i, a, f2);
         wgt[i] = wgt[a] + wgt[b];
         par[i] = NO_NODE;
         lft[i] = LINK_BITS'(a);
         rgt[i] = LINK_BITS'(b);
         par[a] = LINK_BITS'(i);
         par[b] = LINK_BITS'(i);
      end
      dec_pos = 2 * n - 2;
      built = 1;
   endfunction

   function automatic answer_type codec_answer(op_type op, logic [4:0] idx, logic [15:0] w,
                                               logic bv);
      answer_type r;
      int unsigned n, root, c, p, steps, pos, nxt;
      r = '{ST_OK, 1'b0, 5'd0, 31'd0, 5'd0};
      n = live_count();
      root = 2 * n - 2;
      if (op == OP_LOAD) begin
         if (idx >= n) r.st = ST_BAD_INDEX;
         else wgt[idx] = w;
      end else if (op == OP_BUILD) begin
         grow_tree(n);
      end else if (!built) begin
         r.st = ST_NOT_BUILT;
      end else if (op == OP_ENCODE) begin
         if (idx >= n) begin
            r.st = ST_BAD_INDEX;
         end else begin
            c = idx;
            steps = 0;
            p = par[c];
            while (p != NO_NODE && p < NODE_COUNT && steps < 31) begin
               if (lft[p] != c) r.code[r.len] = 1'b1;
               r.len++;
               steps++;
               c = p;
               p = par[c];
            end
         end
      end else begin
         pos = dec_pos;
         if (pos > root) pos = root;
         nxt = bv ? rgt[pos] : lft[pos];
         if (nxt > root) begin
            dec_pos = root;
         end else if (lft[nxt] == NO_NODE && rgt[nxt] == NO_NODE) begin
            r.sym_valid = 1'b1;
            r.sym = nxt[4:0];
            dec_pos = root;
         end else begin
            dec_pos = nxt;
         end
      end
      return r;
   endfunction

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task automatic send(op_type op, logic [4:0] idx, logic [15:0] w, logic bv,
                       bit typed = 0, status_type st = ST_OK);
      answer_type a;
      if (!calm && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 25);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, bv, w, idx};
      do @(posedge clock); while (!req_tready);
      a = codec_answer(op, idx, w, bv);
      if (typed) a = '{st, 1'b0, 5'd0, 31'd0, 5'd0};
      pending_answers.push_back(a);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [31:0] v);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cnt_reg = v[5:0];
      built = 0;
      dec_pos = 0;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: random stall, compare against the oldest expectation
   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 25);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               report("unexpected transfer", 1, 0);
            end else begin
               e = pending_answers.pop_front();
               if (rsp_tuser[1:0] !== e.st) report("status", rsp_tuser[1:0], e.st);
               if (rsp_tuser[2] !== e.sym_valid) report("symbol_valid", rsp_tuser[2], e.sym_valid);
               if (rsp_tdata[4:0] !== e.sym) report("symbol", rsp_tdata[4:0], e.sym);
               if (rsp_tdata[35:5] !== e.code) report("code_bits", rsp_tdata[35:5], e.code);
               if (rsp_tdata[40:36] !== e.len) report("code_length", rsp_tdata[40:36], e.len);
            end
         end
      end
   end

   // watchdog: fails the run when stall_cnt, reset on each request or result transfer, passes its limit
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt > 40000) begin
            $display("FAIL huffman_tree_codec");
            $finish;
         end
      end
   end

   row_type table_rows[] = '{
      '{OP_ENCODE, 5'd0,  16'd0,     1'b0, 1, ST_NOT_BUILT},
      '{OP_DECODE, 5'd0,  16'd0,     1'b1, 1, ST_NOT_BUILT},
      '{OP_LOAD,   5'd31, 16'hFFFF,  1'b0, 1, ST_BAD_INDEX},
      '{OP_LOAD,   5'd0,  16'hFFFF,  1'b0, 1, ST_OK},
      '{OP_BUILD,  5'd0,  16'd0,     1'b0, 1, ST_OK},
      '{OP_ENCODE, 5'd0,  16'd0,     1'b0, 0, ST_OK},
      '{OP_ENCODE, 5'd26, 16'd0,     1'b0, 0, ST_OK},
      '{OP_ENCODE, 5'd27, 16'd0,     1'b0, 1, ST_BAD_INDEX},
      '{OP_DECODE, 5'd0,  16'd0,     1'b0, 0, ST_OK},
      '{OP_DECODE, 5'd0,  16'd0,     1'b1, 0, ST_OK},
      '{OP_DECODE, 5'd0,  16'd0,     1'b1, 0, ST_OK},
      '{OP_DECODE, 5'd0,  16'd0,     1'b0, 0, ST_OK},
      '{OP_LOAD,   5'd3,  16'd0,     1'b0, 1, ST_OK},
      '{OP_ENCODE, 5'd3,  16'd0,     1'b0, 0, ST_OK},
      '{OP_BUILD,  5'd0,  16'd0,     1'b0, 1, ST_OK},
      '{OP_ENCODE, 5'd3,  16'd0,     1'b0, 0, ST_OK},
      '{OP_ENCODE, 5'd31, 16'd0,     1'b0, 1, ST_BAD_INDEX}
   };

   int unsigned counts[] = '{2, 32, 0, 63, 5, 17, 27};
   int unsigned n_now;
   int unsigned pick;

   initial begin
      errors = 0;
      calm = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cnt_reg = COUNT_RESET;
      built = 0;
      dec_pos = 0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         wgt[i] = 0;
         par[i] = 0;
         lft[i] = 0;
         rgt[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // leaves 1 to 26 get a weight here, leaf 0 in the table, before any build; ties on purpose
      for (int i = 1; i < 27; i++)
         send(OP_LOAD, i[4:0], 16'($urandom_range(1, 8)), 1'b0, 1, ST_OK);
      foreach (table_rows[k])
         send(table_rows[k].op, table_rows[k].idx, table_rows[k].wt, table_rows[k].bv,
              table_rows[k].typed, table_rows[k].st);
      write_count(32);
      for (int i = 27; i < 32; i++)
         send(OP_LOAD, i[4:0], 16'($urandom), 1'b0, 1, ST_OK);

      foreach (counts[c]) begin
         write_count(counts[c]);
         calm = (c == 1);
         n_now = live_count();
         send(OP_BUILD, 5'($urandom), 16'($urandom), 1'($urandom));
         for (int k = 0; k < 235; k++) begin
            if (c == 3 && k == 100) drain();
            pick = $urandom_range(99);
            if (pick < 18)
               send(OP_LOAD, 5'($urandom), ($urandom_range(1) ? 16'($urandom)
                    : 16'($urandom_range(3))), 1'($urandom));
            else if (pick < 21)
               send(OP_BUILD, 5'($urandom), 16'($urandom), 1'($urandom));
            else if (pick < 55)
               send(OP_ENCODE, ($urandom_range(9) == 0 ? 5'($urandom)
                    : 5'($urandom_range(n_now - 1))), 16'($urandom), 1'($urandom));
            else
               send(OP_DECODE, 5'($urandom), 16'($urandom), 1'($urandom));
         end
      end
      calm = 0;
      drain();
      if (errors == 0)
         $display("PASS huffman_tree_codec");
      else
         $display("FAIL huffman_tree_codec");
      $finish;
   end

endmodule
